// ===== sv/flsh_pkg.sv =====
// Shared types, widths and constants of the fragment light shader.
package flsh_pkg;

   // fixed-point format of unit vectors: Q2.14
   localparam int Q_BITS = 14;
   localparam int Q_ONE = 1 << Q_BITS;
   localparam int Q_HALF = Q_ONE / 2;

   // field widths
   localparam int COORD_W = 16;
   localparam int COLOR_W = 8;
   localparam int VEC_W = COORD_W + 2;
   localparam int UNIT_W = Q_BITS + 2;

   // normalizer widths
   localparam int SQ_W = 2 * (COORD_W + 1) - 1;
   localparam int SUM_W = SQ_W + 1;
   localparam int ISQRT_IN_W = SUM_W + 2 * Q_BITS;
   localparam int ROOT_W = ISQRT_IN_W / 2;
   localparam int DIV_Q_W = Q_BITS + 2;
   localparam int DIV_NUM_W = VEC_W + 2 * Q_BITS + 1;

   // pipeline depths
   localparam int UNIT_LAT = 2 + ROOT_W + 1 + DIV_Q_W + 1;
   localparam int POW_STEPS = 5;
   localparam int LIGHT_LAT = 2 + POW_STEPS + 3;
   localparam int NL_DLY = UNIT_LAT + 1;
   localparam int SIDE_DLY = 2 * UNIT_LAT + 1;
   localparam int PIPE_LAT = 1 + UNIT_LAT + 1 + UNIT_LAT + LIGHT_LAT;

   // lighting constants, weights in 1/100
   localparam int LAMBERT_MIN = 164;
   localparam int W_DIFF_PHONG = 20;
   localparam int W_SPEC_PHONG = 64;
   localparam int W_DIFF_LAMBERT = 80;
   localparam int W_AMBIENT = 20 * Q_ONE;
   localparam int CH_HALF = 819200;
   localparam int CH_SHIFT = 16;
   localparam int DIV25_MUL = 5243;
   localparam int DIV25_SH = 17;
   localparam int CH_MAX = 255;

   // configuration registers
   localparam int CSR_IDX_W = 3;
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LIGHT_X = 3'd0,
      CSR_LIGHT_Y = 3'd1,
      CSR_LIGHT_Z = 3'd2,
      CSR_EYE_X = 3'd3,
      CSR_EYE_Y = 3'd4,
      CSR_EYE_Z = 3'd5
   } csr_idx_type;

   localparam logic signed [COORD_W-1:0] LIGHT_X_RST = 16'sd100;
   localparam logic signed [COORD_W-1:0] LIGHT_Y_RST = 16'sd100;
   localparam logic signed [COORD_W-1:0] LIGHT_Z_RST = -16'sd1000;
   localparam logic signed [COORD_W-1:0] EYE_RST = 16'sd0;

   typedef logic signed [VEC_W-1:0] vec_type [3];
   typedef logic signed [UNIT_W-1:0] unit_vec_type [3];

   // per-fragment data that rides alongside the vector math
   typedef struct packed {
      logic mode;
      logic [COLOR_W-1:0] color_r;
      logic [COLOR_W-1:0] color_g;
      logic [COLOR_W-1:0] color_b;
   } side_type;

endpackage

// ===== sv/flsh_isqrt.sv =====
// Pipelined integer square root, one root bit per stage.
module flsh_isqrt import flsh_pkg::*; (
   input logic clock,
   input logic en,
   input logic [ISQRT_IN_W-1:0] radicand,
   output logic [ROOT_W-1:0] root
);

   logic [ISQRT_IN_W-1:0] rem_ff [ROOT_W];
   logic [ROOT_W-1:0] root_ff [ROOT_W];

   for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
      localparam int BIT = ROOT_W - 1 - k;
      logic [ISQRT_IN_W-1:0] rem_prev;
      logic [ISQRT_IN_W-1:0] rem_in;
      logic [ISQRT_IN_W-1:0] trial;
      logic [ROOT_W-1:0] root_prev;
      logic [ROOT_W-1:0] root_in;

      if (k == 0) begin : g_first
         assign rem_prev = radicand;
         assign root_prev = '0;
      end else begin : g_next
         assign rem_prev = rem_ff[k-1];
         assign root_prev = root_ff[k-1];
      end

      // (r + 2^b)^2 - r^2 = r * 2^(b+1) + 2^(2b)
      always_comb begin
         trial = (ISQRT_IN_W'(root_prev) << (BIT + 1)) | (ISQRT_IN_W'(1) << (2 * BIT));
         if (rem_prev >= trial) begin
            rem_in = rem_prev - trial;
            root_in = root_prev | (ROOT_W'(1) << BIT);
         end else begin
            rem_in = rem_prev;
            root_in = root_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= rem_in;
            root_ff[k] <= root_in;
         end
      end
   end

   assign root = root_ff[ROOT_W-1];

endmodule

// ===== sv/flsh_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
module flsh_div import flsh_pkg::*; (
   input logic clock,
   input logic en,
   input logic [DIV_NUM_W-1:0] num,
   input logic [ROOT_W-1:0] den,
   output logic [DIV_Q_W-1:0] quot
);

   logic [DIV_NUM_W-1:0] rem_ff [DIV_Q_W];
   logic [ROOT_W-1:0] den_ff [DIV_Q_W];
   logic [DIV_Q_W-1:0] quo_ff [DIV_Q_W];

   for (genvar k = 0; k < DIV_Q_W; k++) begin : g_stage
      localparam int BIT = DIV_Q_W - 1 - k;
      logic [DIV_NUM_W-1:0] rem_prev;
      logic [DIV_NUM_W-1:0] rem_in;
      logic [DIV_NUM_W-1:0] trial;
      logic [ROOT_W-1:0] den_prev;
      logic [DIV_Q_W-1:0] quo_prev;
      logic [DIV_Q_W-1:0] quo_in;

      if (k == 0) begin : g_first
         assign rem_prev = num;
         assign den_prev = den;
         assign quo_prev = '0;
      end else begin : g_next
         assign rem_prev = rem_ff[k-1];
         assign den_prev = den_ff[k-1];
         assign quo_prev = quo_ff[k-1];
      end

      // compare and subtract the shifted divisor
      always_comb begin
         trial = DIV_NUM_W'(den_prev) << BIT;
         if (rem_prev >= trial) begin
            rem_in = rem_prev - trial;
            quo_in = quo_prev | (DIV_Q_W'(1) << BIT);
         end else begin
            rem_in = rem_prev;
            quo_in = quo_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= rem_in;
            den_ff[k] <= den_prev;
            quo_ff[k] <= quo_in;
         end
      end
   end

   assign quot = quo_ff[DIV_Q_W-1];

endmodule

// ===== sv/flsh_unit3.sv =====
// Vector normalizer: squares, root, per-component divide, clamp to Q2.14.
module flsh_unit3 import flsh_pkg::*; (
   input logic clock,
   input logic en,
   input vec_type v,
   output unit_vec_type u
);

   localparam int V_DLY = 2 + ROOT_W;

   logic [SQ_W-1:0] sq_ff [3];
   logic [ISQRT_IN_W-1:0] rad_ff;
   vec_type v_dly_ff [V_DLY];
   logic [ROOT_W-1:0] root;
   logic [DIV_NUM_W-1:0] num_ff [3];
   logic [ROOT_W-1:0] den_ff;
   logic [2:0] neg_ff;
   logic [2:0] neg_dly_ff [DIV_Q_W];
   logic [DIV_Q_W-1:0] quot [3];
   unit_vec_type u_ff;

   logic [SQ_W-1:0] sq_in [3];
   logic [SUM_W-1:0] sum;
   logic [ROOT_W-1:0] den_in;
   logic [DIV_NUM_W-1:0] num_in [3];
   logic [2:0] neg_in;
   unit_vec_type u_in;

   // squares of the components
   always_comb begin
      logic signed [2*VEC_W-1:0] prod;
      for (int i = 0; i < 3; i++) begin
         prod = v[i] * v[i];
         sq_in[i] = SQ_W'(prod);
      end
   end

   assign sum = SUM_W'(sq_ff[0]) + SUM_W'(sq_ff[1]) + SUM_W'(sq_ff[2]);

   always_ff @(posedge clock) begin
      if (en) begin
         sq_ff <= sq_in;
         rad_ff <= ISQRT_IN_W'(sum) << (2 * Q_BITS);
      end
   end

   flsh_isqrt u_isqrt (
      .clock(clock),
      .en(en),
      .radicand(rad_ff),
      .root(root)
   );

   // components wait for the root
   always_ff @(posedge clock) begin
      if (en) begin
         v_dly_ff[0] <= v;
         for (int k = 1; k < V_DLY; k++) v_dly_ff[k] <= v_dly_ff[k-1];
      end
   end

   // dividend with half divisor added for round-half-away; zero vector divides by one
   always_comb begin
      logic [VEC_W-1:0] mag;
      den_in = (root == '0) ? ROOT_W'(1) : root;
      for (int i = 0; i < 3; i++) begin
         neg_in[i] = v_dly_ff[V_DLY-1][i][VEC_W-1];
         mag = neg_in[i] ? VEC_W'(-v_dly_ff[V_DLY-1][i]) : VEC_W'(v_dly_ff[V_DLY-1][i]);
         num_in[i] = (DIV_NUM_W'(mag) << (2 * Q_BITS)) + DIV_NUM_W'(den_in >> 1);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         num_ff <= num_in;
         den_ff <= den_in;
         neg_ff <= neg_in;
      end
   end

   for (genvar i = 0; i < 3; i++) begin : g_div
      flsh_div u_div (
         .clock(clock),
         .en(en),
         .num(num_ff[i]),
         .den(den_ff),
         .quot(quot[i])
      );
   end

   always_ff @(posedge clock) begin
      if (en) begin
         neg_dly_ff[0] <= neg_ff;
         for (int k = 1; k < DIV_Q_W; k++) neg_dly_ff[k] <= neg_dly_ff[k-1];
      end
   end

   // clamp to one and restore sign
   always_comb begin
      logic [DIV_Q_W-1:0] qc;
      for (int i = 0; i < 3; i++) begin
         qc = (quot[i] > DIV_Q_W'(Q_ONE)) ? DIV_Q_W'(Q_ONE) : quot[i];
         u_in[i] = neg_dly_ff[DIV_Q_W-1][i] ? -UNIT_W'(qc) : UNIT_W'(qc);
      end
   end

   always_ff @(posedge clock) begin
      if (en) u_ff <= u_in;
   end

   assign u = u_ff;

endmodule

// ===== sv/flsh_light.sv =====
// Lighting back end: dot products, specular power, weight, channel scaling.
module flsh_light import flsh_pkg::*; (
   input logic clock,
   input logic en,
   input unit_vec_type n,
   input unit_vec_type l,
   input unit_vec_type h,
   input side_type side,
   output logic [COLOR_W-1:0] out_r,
   output logic [COLOR_W-1:0] out_g,
   output logic [COLOR_W-1:0] out_b
);

   localparam int DOT_W = 2 * UNIT_W;
   localparam int S_W = Q_BITS + 1;
   localparam int W_W = 21;
   localparam int P_W = 29;
   localparam int X_W = P_W - CH_SHIFT;
   localparam int M_W = X_W + 13;
   localparam int O_W = M_W - DIV25_SH;

   logic signed [DOT_W-1:0] pnl_ff [3];
   logic signed [DOT_W-1:0] pnh_ff [3];
   side_type side0_ff;
   logic [S_W-1:0] s_ff [POW_STEPS+1];
   logic [S_W-1:0] d_ff [POW_STEPS+1];
   side_type sd_ff [POW_STEPS+1];
   logic [W_W-1:0] w_ff;
   side_type side_w_ff;
   logic [P_W-1:0] p_ff [3];
   logic [COLOR_W-1:0] out_ff [3];

   logic signed [DOT_W-1:0] pnl_in [3];
   logic signed [DOT_W-1:0] pnh_in [3];
   logic [S_W-1:0] d_in;
   logic [S_W-1:0] s_in;
   logic [W_W-1:0] w_in;
   logic [P_W-1:0] p_in [3];
   logic [COLOR_W-1:0] out_in [3];

   // dot of two unit vectors: divide by one, round half away, clamp
   function automatic logic signed [UNIT_W-1:0] dot_round(input logic signed [DOT_W-1:0] sum);
      logic [DOT_W-1:0] mag;
      logic [DOT_W-1:0] rnd;
      mag = sum[DOT_W-1] ? DOT_W'(-sum) : DOT_W'(sum);
      rnd = (mag + DOT_W'(Q_HALF)) >> Q_BITS;
      if (rnd > DOT_W'(Q_ONE)) rnd = DOT_W'(Q_ONE);
      return sum[DOT_W-1] ? -UNIT_W'(rnd) : UNIT_W'(rnd);
   endfunction

   // component products
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         pnl_in[i] = n[i] * l[i];
         pnh_in[i] = n[i] * h[i];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pnl_ff <= pnl_in;
         pnh_ff <= pnh_in;
         side0_ff <= side;
      end
   end

   // diffuse term per mode, clipped specular base
   always_comb begin
      logic signed [UNIT_W-1:0] dnl;
      logic signed [UNIT_W-1:0] dnh;
      dnl = dot_round(pnl_ff[0] + pnl_ff[1] + pnl_ff[2]);
      dnh = dot_round(pnh_ff[0] + pnh_ff[1] + pnh_ff[2]);
      if (side0_ff.mode) begin
         if (dnl < UNIT_W'(LAMBERT_MIN)) d_in = S_W'(LAMBERT_MIN);
         else d_in = S_W'(dnl);
      end else begin
         d_in = dnl[UNIT_W-1] ? '0 : S_W'(dnl);
      end
      s_in = dnh[UNIT_W-1] ? '0 : S_W'(dnh);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s_ff[0] <= s_in;
         d_ff[0] <= d_in;
         sd_ff[0] <= side0_ff;
      end
   end

   // specular power 32 by five rounded squarings
   for (genvar k = 1; k <= POW_STEPS; k++) begin : g_pow
      logic [2*S_W-1:0] sq;
      assign sq = s_ff[k-1] * s_ff[k-1];
      always_ff @(posedge clock) begin
         if (en) begin
            s_ff[k] <= S_W'((sq + (2*S_W)'(Q_HALF)) >> Q_BITS);
            d_ff[k] <= d_ff[k-1];
            sd_ff[k] <= sd_ff[k-1];
         end
      end
   end

   // light weight
   always_comb begin
      if (sd_ff[POW_STEPS].mode) begin
         w_in = W_W'(W_DIFF_LAMBERT) * W_W'(d_ff[POW_STEPS]) + W_W'(W_AMBIENT);
      end else begin
         w_in = W_W'(W_DIFF_PHONG) * W_W'(d_ff[POW_STEPS])
              + W_W'(W_SPEC_PHONG) * W_W'(s_ff[POW_STEPS]) + W_W'(W_AMBIENT);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         w_ff <= w_in;
         side_w_ff <= sd_ff[POW_STEPS];
      end
   end

   // color times weight plus half of the scale
   always_comb begin
      p_in[0] = P_W'(side_w_ff.color_r) * P_W'(w_ff) + P_W'(CH_HALF);
      p_in[1] = P_W'(side_w_ff.color_g) * P_W'(w_ff) + P_W'(CH_HALF);
      p_in[2] = P_W'(side_w_ff.color_b) * P_W'(w_ff) + P_W'(CH_HALF);
   end

   always_ff @(posedge clock) begin
      if (en) p_ff <= p_in;
   end

   // scale is 2^16 * 25: shift, then reciprocal multiply (exact over this range); saturate
   always_comb begin
      logic [X_W-1:0] x;
      logic [M_W-1:0] m;
      logic [O_W-1:0] o;
      for (int i = 0; i < 3; i++) begin
         x = X_W'(p_ff[i] >> CH_SHIFT);
         m = M_W'(x) * M_W'(DIV25_MUL);
         o = O_W'(m >> DIV25_SH);
         out_in[i] = (o > O_W'(CH_MAX)) ? COLOR_W'(CH_MAX) : COLOR_W'(o);
      end
   end

   always_ff @(posedge clock) begin
      if (en) out_ff <= out_in;
   end

   assign out_r = out_ff[0];
   assign out_g = out_ff[1];
   assign out_b = out_ff[2];

endmodule

// ===== sv/fragment_light_shader_core.sv =====
// Top level of the fragment light shader: config registers, pipeline control, datapath.
//
//   port group   direction  handshake          word
//   req_*        in         req_valid/stall    mode, position, normal, surface color
//   rsp_*        out        rsp_valid/stall    shaded color
//   csr_*        in         csr_valid/ready    register index and 16-bit value
//
// One fragment per cycle enters while the output word is not stalled. The pipeline depth
// is set by two normalizers in series, each a 31-stage square root and 16-stage divider.
// Reset clears the valid bits and loads the light and eye defaults.
// A stalled output word freezes the whole pipeline, and req_stall rises in the same cycle.
module fragment_light_shader_core import flsh_pkg::*; (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_stall,
   input logic req_mode,
   input logic signed [COORD_W-1:0] req_pos_x,
   input logic signed [COORD_W-1:0] req_pos_y,
   input logic signed [COORD_W-1:0] req_pos_z,
   input logic signed [COORD_W-1:0] req_norm_x,
   input logic signed [COORD_W-1:0] req_norm_y,
   input logic signed [COORD_W-1:0] req_norm_z,
   input logic [COLOR_W-1:0] req_surface_r,
   input logic [COLOR_W-1:0] req_surface_g,
   input logic [COLOR_W-1:0] req_surface_b,
   output logic rsp_valid,
   input logic rsp_stall,
   output logic [COLOR_W-1:0] rsp_out_r,
   output logic [COLOR_W-1:0] rsp_out_g,
   output logic [COLOR_W-1:0] rsp_out_b,
   input logic csr_valid,
   output logic csr_ready,
   input logic [CSR_IDX_W-1:0] csr_index,
   input logic [COORD_W-1:0] csr_data
);

   logic signed [COORD_W-1:0] light_x_ff, light_y_ff, light_z_ff;
   logic signed [COORD_W-1:0] eye_x_ff, eye_y_ff, eye_z_ff;
   logic [PIPE_LAT-1:0] vld_ff;
   logic en;

   vec_type lv_ff, vv_ff, nv_ff, hv_ff;
   side_type side_ff;
   side_type side_dly_ff [SIDE_DLY];
   unit_vec_type l_unit, n_unit, v_unit, h_unit;
   unit_vec_type l_dly_ff [NL_DLY];
   unit_vec_type n_dly_ff [NL_DLY];

   // configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         light_x_ff <= LIGHT_X_RST;
         light_y_ff <= LIGHT_Y_RST;
         light_z_ff <= LIGHT_Z_RST;
         eye_x_ff <= EYE_RST;
         eye_y_ff <= EYE_RST;
         eye_z_ff <= EYE_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_idx_type'(csr_index))
            CSR_LIGHT_X: light_x_ff <= csr_data;
            CSR_LIGHT_Y: light_y_ff <= csr_data;
            CSR_LIGHT_Z: light_z_ff <= csr_data;
            CSR_EYE_X: eye_x_ff <= csr_data;
            CSR_EYE_Y: eye_y_ff <= csr_data;
            CSR_EYE_Z: eye_z_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // global advance: hold everything while the output word waits
   assign en = !(rsp_valid && rsp_stall);
   assign req_stall = !en;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[PIPE_LAT-2:0], req_valid};
      end
   end

   assign rsp_valid = vld_ff[PIPE_LAT-1];

   // light, eye and normal vectors
   always_ff @(posedge clock) begin
      if (en) begin
         lv_ff[0] <= VEC_W'(light_x_ff) - VEC_W'(req_pos_x);
         lv_ff[1] <= VEC_W'(light_y_ff) - VEC_W'(req_pos_y);
         lv_ff[2] <= VEC_W'(light_z_ff) - VEC_W'(req_pos_z);
         vv_ff[0] <= VEC_W'(eye_x_ff) - VEC_W'(req_pos_x);
         vv_ff[1] <= VEC_W'(eye_y_ff) - VEC_W'(req_pos_y);
         vv_ff[2] <= VEC_W'(eye_z_ff) - VEC_W'(req_pos_z);
         nv_ff[0] <= VEC_W'(req_norm_x);
         nv_ff[1] <= VEC_W'(req_norm_y);
         nv_ff[2] <= VEC_W'(req_norm_z);
         side_ff <= '{mode: req_mode, color_r: req_surface_r,
                      color_g: req_surface_g, color_b: req_surface_b};
      end
   end

   flsh_unit3 u_norm_l (.clock(clock), .en(en), .v(lv_ff), .u(l_unit));
   flsh_unit3 u_norm_n (.clock(clock), .en(en), .v(nv_ff), .u(n_unit));
   flsh_unit3 u_norm_v (.clock(clock), .en(en), .v(vv_ff), .u(v_unit));

   // half vector
   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) hv_ff[i] <= VEC_W'(l_unit[i]) + VEC_W'(v_unit[i]);
      end
   end

   flsh_unit3 u_norm_h (.clock(clock), .en(en), .v(hv_ff), .u(h_unit));

   // N and L wait for H; fragment data waits for both normalizers
   always_ff @(posedge clock) begin
      if (en) begin
         l_dly_ff[0] <= l_unit;
         n_dly_ff[0] <= n_unit;
         for (int k = 1; k < NL_DLY; k++) begin
            l_dly_ff[k] <= l_dly_ff[k-1];
            n_dly_ff[k] <= n_dly_ff[k-1];
         end
         side_dly_ff[0] <= side_ff;
         for (int k = 1; k < SIDE_DLY; k++) side_dly_ff[k] <= side_dly_ff[k-1];
      end
   end

   flsh_light u_light (
      .clock(clock),
      .en(en),
      .n(n_dly_ff[NL_DLY-1]),
      .l(l_dly_ff[NL_DLY-1]),
      .h(h_unit),
      .side(side_dly_ff[SIDE_DLY-1]),
      .out_r(rsp_out_r),
      .out_g(rsp_out_g),
      .out_b(rsp_out_b)
   );

`ifndef SYNTH
   // a frozen pipeline keeps every word in place
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      req_stall |=> (vld_ff == $past(vld_ff)))
      else $error("valid bits moved during stall");

   // last stage before the output always lands when the pipe advances
   a_advance: assert property (@(posedge clock) disable iff (reset)
      (!req_stall && vld_ff[PIPE_LAT-2]) |=> rsp_valid)
      else $error("word lost before the output register");

   // reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("output valid after reset");
`endif

endmodule
